[rtl/core/vbd_pkg.sv]
// shared types and constants for the vertical blend deinterlacer
`default_nettype none

package vbd_pkg;

   // pixel and position widths
   localparam int PIX_W     = 8;
   localparam int ROW_W     = 12;
   localparam int COL_OUT_W = 11;

   // configuration port
   localparam int CSR_W     = 12;
   localparam int CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_LINE_WIDTH   = 2'd0,
      REG_FRAME_HEIGHT = 2'd1
   } csr_reg_type;

   localparam logic [CSR_W-1:0] LINE_WIDTH_RST   = 12'd720;
   localparam logic [CSR_W-1:0] FRAME_HEIGHT_RST = 12'd480;

   // default line store depth
   localparam int MAX_LINE_WIDTH_DEF = 2048;

   // stream widths
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 32;

   // result queue
   localparam int MAX_RESULTS = 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);

   // one result beat
   typedef struct packed {
      logic                 frame_end;
      logic                 last_of_run;
      logic [COL_OUT_W-1:0] col;
      logic [ROW_W-1:0]     row;
      logic [PIX_W-1:0]     pixel;
   } vbd_result_type;

endpackage

`default_nettype wire

[rtl/core/vbd_ram.sv]
// generic single write port, single read port ram with registered read
`default_nettype none

module vbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read, old data on a same-address collision
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

[rtl/core/vbd_line_core.sv]
// raster counters, line stores with read-modify-write and the 1-2-1 blend
`default_nettype none

module vbd_line_core #(
   parameter int MAX_LINE_WIDTH = vbd_pkg::MAX_LINE_WIDTH_DEF,
   localparam int COL_W = $clog2(MAX_LINE_WIDTH)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        item_take,
   input  wire logic [vbd_pkg::PIX_W-1:0]   item_pixel,
   input  wire logic                        restart,
   input  wire logic [COL_W-1:0]            width_last,
   input  wire logic [vbd_pkg::ROW_W-1:0]   height_last,
   output logic      [vbd_pkg::RCNT_W-1:0]  res_count,
   output vbd_pkg::vbd_result_type          res_first,
   output vbd_pkg::vbd_result_type          res_second
);

   import vbd_pkg::*;

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic             s1_vld_ff, s1_vld_in;
   logic [PIX_W-1:0] s1_pix_ff, s1_pix_in;
   logic [COL_W-1:0] s1_col_ff, s1_col_in;
   logic [ROW_W-1:0] s1_row_ff, s1_row_in;
   logic             s1_first_ff, s1_first_in;
   logic             s1_last_row_ff, s1_last_row_in;
   logic             s1_row_zero_ff, s1_row_zero_in;
   logic             s1_last_col_ff, s1_last_col_in;

   logic             fwd_ff, fwd_in;
   logic [PIX_W-1:0] fwd_old_ff, fwd_old_in;
   logic [PIX_W-1:0] fwd_new_ff, fwd_new_in;

   logic [PIX_W-1:0] older_rd, newer_rd;
   logic [PIX_W-1:0] cur_old, cur_new;
   logic [PIX_W:0]   avg_sum;
   logic [PIX_W+1:0] mid_sum;
   logic [PIX_W-1:0] avg_pix, mid_pix;

   // position of the next input byte
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      priority if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (item_take) begin
         if (col_ff == width_last) begin
            col_in = '0;
            row_in = (row_ff == height_last) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end else begin
         col_in = col_ff;
      end
   end

   // blend stage capture, lines up with the ram read data
   always_comb begin
      s1_vld_in      = item_take;
      s1_pix_in      = s1_pix_ff;
      s1_col_in      = s1_col_ff;
      s1_row_in      = s1_row_ff;
      s1_first_in    = s1_first_ff;
      s1_last_row_in = s1_last_row_ff;
      s1_row_zero_in = s1_row_zero_ff;
      s1_last_col_in = s1_last_col_ff;
      if (item_take) begin
         s1_pix_in      = item_pixel;
         s1_col_in      = col_ff;
         s1_row_in      = row_ff;
         s1_first_in    = (row_ff == ROW_W'(1));
         s1_last_row_in = (row_ff == height_last);
         s1_row_zero_in = (row_ff == '0);
         s1_last_col_in = (col_ff == width_last);
      end
   end

   // forward the write-back when the next beat reads the same column
   always_comb begin
      fwd_in     = item_take && s1_vld_ff && (s1_col_ff == col_ff);
      fwd_old_in = cur_new;
      fwd_new_in = s1_pix_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         s1_vld_ff <= 1'b0;
         fwd_ff    <= 1'b0;
      end else begin
         col_ff    <= col_in;
         row_ff    <= row_in;
         s1_vld_ff <= s1_vld_in;
         fwd_ff    <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_pix_ff      <= s1_pix_in;
      s1_col_ff      <= s1_col_in;
      s1_row_ff      <= s1_row_in;
      s1_first_ff    <= s1_first_in;
      s1_last_row_ff <= s1_last_row_in;
      s1_row_zero_ff <= s1_row_zero_in;
      s1_last_col_ff <= s1_last_col_in;
      fwd_old_ff     <= fwd_old_in;
      fwd_new_ff     <= fwd_new_in;
   end

   // line stores: row r-2 and row r-1, same address on both
   vbd_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_LINE_WIDTH)
   ) u_older_line (
      .clock   (clock),
      .wr_en   (s1_vld_ff),
      .wr_addr (s1_col_ff),
      .wr_data (cur_new),
      .rd_en   (item_take),
      .rd_addr (col_ff),
      .rd_data (older_rd)
   );

   vbd_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_LINE_WIDTH)
   ) u_newer_line (
      .clock   (clock),
      .wr_en   (s1_vld_ff),
      .wr_addr (s1_col_ff),
      .wr_data (s1_pix_ff),
      .rd_en   (item_take),
      .rd_addr (col_ff),
      .rd_data (newer_rd)
   );

   // blend arithmetic
   always_comb begin
      cur_old = fwd_ff ? fwd_old_ff : older_rd;
      cur_new = fwd_ff ? fwd_new_ff : newer_rd;
      avg_sum = (PIX_W+1)'(cur_new) + (PIX_W+1)'(s1_pix_ff) + (PIX_W+1)'(1);
      mid_sum = (PIX_W+2)'(cur_old) + ((PIX_W+2)'(cur_new) << 1)
              + (PIX_W+2)'(s1_pix_ff) + (PIX_W+2)'(2);
      avg_pix = avg_sum[PIX_W:1];
      mid_pix = mid_sum[PIX_W+1:2];
   end

   // results of the beat in the blend stage
   always_comb begin
      res_first.pixel       = s1_first_ff ? avg_pix : mid_pix;
      res_first.row         = s1_row_ff - 1'b1;
      res_first.col         = COL_OUT_W'(s1_col_ff);
      res_first.last_of_run = !s1_last_row_ff;
      res_first.frame_end   = 1'b0;

      res_second.pixel       = avg_pix;
      res_second.row         = s1_row_ff;
      res_second.col         = COL_OUT_W'(s1_col_ff);
      res_second.last_of_run = 1'b1;
      res_second.frame_end   = s1_last_col_ff;

      if (!s1_vld_ff || s1_row_zero_ff) begin
         res_count = RCNT_W'(0);
      end else if (s1_last_row_ff) begin
         res_count = RCNT_W'(2);
      end else begin
         res_count = RCNT_W'(1);
      end
   end

`ifndef ASSERT_OFF
   // forwarding only ever follows a beat in the blend stage
   a_fwd_follows_beat: assert property (@(posedge clock) disable iff (reset)
      fwd_ff |-> $past(s1_vld_ff))
      else $error("forward taken without a preceding beat");

   // a frame restart puts the raster position back to the origin
   a_restart_origin: assert property (@(posedge clock) disable iff (reset)
      restart |=> (col_ff == '0) && (row_ff == '0))
      else $error("raster position not cleared on restart");

   // raster position never runs past the frame geometry
   a_pos_in_frame: assert property (@(posedge clock) disable iff (reset)
      (col_ff <= width_last) && (row_ff <= height_last))
      else $error("raster position outside frame");
`endif

endmodule

`default_nettype wire

[rtl/core/vbd_out_queue.sv]
// small result queue taking up to two beats a cycle and giving one
`default_nettype none

module vbd_out_queue (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [vbd_pkg::RCNT_W-1:0]  push_count,
   input  wire vbd_pkg::vbd_result_type     push_first,
   input  wire vbd_pkg::vbd_result_type     push_second,
   input  wire logic                        pop,
   output vbd_pkg::vbd_result_type          head,
   output logic                             not_empty,
   output logic      [vbd_pkg::QCNT_W-1:0]  fill
);

   import vbd_pkg::*;

   vbd_result_type    ent_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic [QPTR_W-1:0] wr_ptr_next;
   logic              do_pop;

   assign do_pop      = pop && (cnt_ff != '0);
   assign wr_ptr_next = wr_ptr_ff + 1'b1;

   // pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push_count);
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + QCNT_W'(push_count) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // entry writes, second beat goes one place after the first
   always_ff @(posedge clock) begin
      if (push_count != '0) begin
         ent_ff[wr_ptr_ff] <= push_first;
      end
      if (push_count == RCNT_W'(2)) begin
         ent_ff[wr_ptr_next] <= push_second;
      end
   end

   assign head      = ent_ff[rd_ptr_ff];
   assign not_empty = (cnt_ff != '0);
   assign fill      = cnt_ff;

`ifndef ASSERT_OFF
   // fill level stays within the storage
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("result queue fill above depth");

   // no push may overrun the queue
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (32'(cnt_ff) + 32'(push_count) - 32'(do_pop)) <= QUEUE_DEPTH)
      else $error("result queue overrun");

   // a lone pop lowers the fill level by one
   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      (do_pop && (push_count == '0)) |=> (cnt_ff == $past(cnt_ff) - 1'b1))
      else $error("pop did not lower fill level");
`endif

endmodule

`default_nettype wire

[rtl/core/vertical_blend_deinterlacer.sv]
// top level of the vertical 1-2-1 blend deinterlacer
`default_nettype none

// Takes a frame as a stream of bytes in raster order and returns the vertically
// blended frame: output row 0 is the rounded mean of source rows 0 and 1, each
// middle row j is (r[j-1] + 2*r[j] + r[j+1] + 2) >> 2 and the last row is the
// rounded mean of the last two source rows. Output row j-1 leaves while source
// row j comes in, so source row 0 gives no results and each byte of the last
// source row gives two (row h-2, then row h-1, same column). Rate: one byte per
// cycle on every row but the last while the result stream is ready; on the last
// row the single result beat per cycle holds input back. Each byte costs one
// read and one write of two line stores of MAX_LINE_WIDTH bytes; the write lands
// in the cycle after the read and is forwarded when the next byte hits the same
// column (one-byte-wide frames). The line stores are not cleared; every read
// whose data is used hits a column written earlier in the same frame. Writing
// line_width or frame_height restarts the frame; configure only while the block
// is idle. line_width 0 acts as 1 and values above MAX_LINE_WIDTH as
// MAX_LINE_WIDTH; frame_height below 2 acts as 2.
module vertical_blend_deinterlacer #(
   parameter int MAX_LINE_WIDTH = vbd_pkg::MAX_LINE_WIDTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // input stream
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [vbd_pkg::REQ_DATA_W-1:0]  req_tdata,  // [7:0] in_pixel
   // result stream
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [7:0] out_pixel, [19:8] out_row, [30:20] out_col, [31] zero
   output logic      [vbd_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                                 rsp_tlast,  // last_of_run
   output logic                                 rsp_tuser,  // [0] frame_end
   // configuration writes
   input  wire logic                            csr_we,
   input  wire logic [vbd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [vbd_pkg::CSR_W-1:0]       csr_wdata
);

   import vbd_pkg::*;

   localparam int COL_W = $clog2(MAX_LINE_WIDTH);

   logic [CSR_W-1:0]  width_ff, width_in;
   logic [CSR_W-1:0]  height_ff, height_in;
   logic              restart;
   logic [COL_W:0]    width_eff;
   logic [COL_W-1:0]  width_last;
   logic [ROW_W-1:0]  height_last;
   logic              item_take;
   logic [RCNT_W-1:0] res_count;
   vbd_result_type    res_first, res_second, head;
   logic              not_empty;
   logic [QCNT_W-1:0] fill;
   logic [QCNT_W:0]   credit;

   // configuration registers
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      restart   = 1'b0;
      if (csr_we) begin
         if (csr_index == REG_LINE_WIDTH) begin
            width_in = csr_wdata;
            restart  = 1'b1;
         end else if (csr_index == REG_FRAME_HEIGHT) begin
            height_in = csr_wdata;
            restart   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= LINE_WIDTH_RST;
         height_ff <= FRAME_HEIGHT_RST;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // effective frame geometry as last column and last row
   always_comb begin
      if (width_ff == '0) begin
         width_eff = (COL_W+1)'(1);
      end else if (32'(width_ff) > MAX_LINE_WIDTH) begin
         width_eff = (COL_W+1)'(MAX_LINE_WIDTH);
      end else begin
         width_eff = (COL_W+1)'(width_ff);
      end
      width_last  = COL_W'(width_eff - 1'b1);
      height_last = (height_ff < CSR_W'(2)) ? ROW_W'(1) : ROW_W'(height_ff - 1'b1);
   end

   // take a beat only when the queue can hold everything in flight
   assign credit     = (QCNT_W+1)'(fill) + (QCNT_W+1)'(res_count);
   assign req_tready = (credit <= (QCNT_W+1)'(QUEUE_DEPTH - MAX_RESULTS));
   assign item_take  = req_tvalid && req_tready;

   vbd_line_core #(
      .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .item_take   (item_take),
      .item_pixel  (req_tdata[PIX_W-1:0]),
      .restart     (restart),
      .width_last  (width_last),
      .height_last (height_last),
      .res_count   (res_count),
      .res_first   (res_first),
      .res_second  (res_second)
   );

   vbd_out_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_count  (res_count),
      .push_first  (res_first),
      .push_second (res_second),
      .pop         (rsp_tready),
      .head        (head),
      .not_empty   (not_empty),
      .fill        (fill)
   );

   // result beat
   assign rsp_tvalid = not_empty;
   assign rsp_tdata  = {1'b0, head.col, head.row, head.pixel};
   assign rsp_tlast  = head.last_of_run;
   assign rsp_tuser  = head.frame_end;

endmodule

`default_nettype wire
